// ===== sv/cba_pkg.sv =====
package cba_pkg;

    localparam int unsigned HEAP_BYTES_DEF  = 32768;
    localparam int unsigned ALIGN_BYTES_DEF = 4;
    localparam int unsigned NUM_HANDLES_DEF = 64;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned HANDLE_W = 6;
    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FIELD_W  = 16;

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC  = 2'd0,
        K_FREE   = 2'd1,
        K_RESIZE = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_ALLOCED  = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_APPLY,
        S_OUT
    } t_state;

endpackage

// ===== sv/cba_if.sv =====
interface cba_req_if;
    logic                          valid;
    logic                          ready;
    logic [cba_pkg::KIND_W-1:0]    kind;
    logic [cba_pkg::HANDLE_W-1:0]  handle;
    logic [cba_pkg::SIZE_W-1:0]    size_bytes;
    modport source (output valid, kind, handle, size_bytes, input ready);
    modport sink   (input valid, kind, handle, size_bytes, output ready);
endinterface

interface cba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cba_pkg::STATUS_W-1:0]  status;
    logic [cba_pkg::FIELD_W-1:0]   block_offset;
    logic [cba_pkg::FIELD_W-1:0]   free_after;
    logic [cba_pkg::FIELD_W-1:0]   move_src;
    logic [cba_pkg::FIELD_W-1:0]   move_dst;
    logic [cba_pkg::FIELD_W-1:0]   move_len;
    modport source (output valid, status, block_offset, free_after, move_src, move_dst,
                    move_len, input ready);
    modport sink   (input valid, status, block_offset, free_after, move_src, move_dst,
                    move_len, output ready);
endinterface

// ===== sv/cba_cell.sv =====
// One handle entry: valid, offset, padded size and rank. The selected cell
// puts its entry on the chain, others pass the incoming one along, so it can
// be read out of the end of the chain; commands are broadcast to all cells.
module cba_cell #(
    parameter int unsigned OFF_W  = 16,
    parameter int unsigned RANK_W = 6,
    parameter int unsigned IDX_W  = 6,
    parameter int unsigned MY_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // broadcast command
    input  logic              i_sel_hit,   // update enable for the selected entry
    input  logic [IDX_W-1:0]  i_sel,       // handle being looked up
    input  logic              i_wr_new,    // allocate into selected entry
    input  logic              i_wr_free,   // clear selected entry
    input  logic              i_wr_size,   // resize selected entry
    input  logic              i_shift,     // adjust later entries
    input  logic              i_shift_up,
    input  logic              i_dec_rank,
    input  logic [OFF_W-1:0]  i_delta,
    input  logic [RANK_W-1:0] i_ref_rank,
    input  logic [OFF_W-1:0]  i_new_off,
    input  logic [OFF_W-1:0]  i_new_size,
    input  logic [RANK_W-1:0] i_new_rank,
    // neighbor chain: match propagates toward the end
    input  logic              i_hit,
    input  logic              i_pvalid,
    input  logic [OFF_W-1:0]  i_poff,
    input  logic [OFF_W-1:0]  i_psize,
    input  logic [RANK_W-1:0] i_prank,
    output logic              o_hit,
    output logic              o_pvalid,
    output logic [OFF_W-1:0]  o_poff,
    output logic [OFF_W-1:0]  o_psize,
    output logic [RANK_W-1:0] o_prank
);
    logic              r_valid;
    logic [OFF_W-1:0]  r_off;
    logic [OFF_W-1:0]  r_size;
    logic [RANK_W-1:0] r_rank;
    logic              w_mine;
    logic              w_later;

    assign w_mine  = (i_sel == IDX_W'(MY_IDX));
    assign w_later = r_valid && (r_rank > i_ref_rank);

    // readout: the matching cell injects its entry, others pass along
    always_comb begin
        if (w_mine) begin
            o_hit    = 1'b1;
            o_pvalid = r_valid;
            o_poff   = r_off;
            o_psize  = r_size;
            o_prank  = r_rank;
        end else begin
            o_hit    = i_hit;
            o_pvalid = i_pvalid;
            o_poff   = i_poff;
            o_psize  = i_psize;
            o_prank  = i_prank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_sel_hit && w_mine && i_wr_new) begin
            r_valid <= 1'b1;
        end else if (i_sel_hit && w_mine && i_wr_free) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sel_hit && w_mine && i_wr_new) begin
            r_off  <= i_new_off;
            r_size <= i_new_size;
            r_rank <= i_new_rank;
        end else if (i_sel_hit && w_mine && i_wr_size) begin
            r_size <= i_new_size;
        end else if (i_shift && w_later) begin
            r_off <= i_shift_up ? r_off + i_delta : r_off - i_delta;
            if (i_dec_rank) begin
                r_rank <= r_rank - RANK_W'(1);
            end
        end
    end
endmodule

// ===== sv/cba_ctrl.sv =====
// Sequencer: looks up the entry, decides the outcome, broadcasts the
// update and holds the result in an output register.
module cba_ctrl
    import cba_pkg::*;
#(
    parameter int unsigned HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int unsigned ALIGN_BYTES = ALIGN_BYTES_DEF,
    parameter int unsigned NUM_HANDLES = NUM_HANDLES_DEF,
    parameter int unsigned OFF_W       = $clog2(HEAP_BYTES + 1),
    parameter int unsigned RANK_W      = $clog2(NUM_HANDLES),
    parameter int unsigned IDX_W       = $clog2(NUM_HANDLES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cba_req_if.sink           req,
    cba_rsp_if.source         rsp,
    output logic [IDX_W-1:0]  o_sel,
    output logic              o_sel_hit,
    output logic              o_wr_new,
    output logic              o_wr_free,
    output logic              o_wr_size,
    output logic              o_shift,
    output logic              o_shift_up,
    output logic              o_dec_rank,
    output logic [OFF_W-1:0]  o_delta,
    output logic [RANK_W-1:0] o_ref_rank,
    output logic [OFF_W-1:0]  o_new_off,
    output logic [OFF_W-1:0]  o_new_size,
    output logic [RANK_W-1:0] o_new_rank,
    input  logic              i_hit,
    input  logic              i_pvalid,
    input  logic [OFF_W-1:0]  i_poff,
    input  logic [OFF_W-1:0]  i_psize,
    input  logic [RANK_W-1:0] i_prank
);
    localparam int unsigned PW = SIZE_W + 1;
    localparam int unsigned CW = $clog2(NUM_HANDLES + 1);
    localparam bit          POW2 = (ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0;
    // reciprocal of the alignment, exact for every 16-bit size
    localparam int unsigned     RK = 23;
    localparam longint unsigned RM = ((longint'(1) << RK) + ALIGN_BYTES - 1) / ALIGN_BYTES;

    t_state  r_state, n_state;
    t_kind   r_kind;
    logic [HANDLE_W-1:0] r_handle;
    logic [PW-1:0]       r_pad;
    logic [OFF_W-1:0]    r_free;
    logic [CW-1:0]       r_live;
    logic [RANK_W-1:0]   r_rank;
    logic [OFF_W-1:0]    r_off, r_old;
    logic                r_valid;
    logic [OFF_W-1:0]    r_delta;
    logic                r_up;
    // result register
    logic [STATUS_W-1:0] r_st;
    logic [FIELD_W-1:0]  r_boff, r_src, r_dst, r_len;

    logic [PW-1:0]    w_pad;
    logic             w_inrange;
    logic [OFF_W:0]   w_top, w_srcx, w_lenx;
    logic             w_ok;
    t_status          w_st;
    logic             w_pad_big, w_grow_big;

    // pad to alignment: mask for powers of two, else remainder by reciprocal multiply
    always_comb begin
        logic [PW-1:0]     s, rem;
        logic [47:0]       prod;
        logic [SIZE_W-1:0] quo;
        s    = PW'(req.size_bytes);
        prod = 48'(req.size_bytes) * 48'(RM);
        quo  = SIZE_W'(prod >> RK);
        if (POW2) begin
            rem   = s & PW'(ALIGN_BYTES - 1);
            w_pad = (rem == '0) ? s : ((s | PW'(ALIGN_BYTES - 1)) + PW'(1));
        end else begin
            rem   = s - PW'(32'(quo) * ALIGN_BYTES);
            w_pad = (rem == '0) ? s : s + PW'(ALIGN_BYTES) - rem;
        end
    end

    assign w_inrange = (32'(r_handle) < NUM_HANDLES);
    assign o_sel     = IDX_W'(r_handle);
    assign w_top     = (OFF_W+1)'(HEAP_BYTES) - (OFF_W+1)'(r_free);
    assign w_srcx    = (OFF_W+1)'(r_off) + (OFF_W+1)'(r_old);
    assign w_lenx    = (w_top > w_srcx) ? w_top - w_srcx : '0;
    assign w_pad_big  = (32'(r_pad) > 32'(r_free));
    assign w_grow_big = (32'(r_pad) > 32'(r_old)) &&
                        (32'(r_pad) - 32'(r_old) > 32'(r_free));

    // outcome of the looked-up request
    always_comb begin
        w_st = ST_OK;
        w_ok = 1'b0;
        case (r_kind)
            K_ALLOC: begin
                if (!w_inrange || w_pad_big) w_st = ST_NO_SPACE;
                else if (r_valid)            w_st = ST_ALLOCED;
                else                         w_ok = 1'b1;
            end
            K_FREE: begin
                if (!w_inrange || !r_valid)  w_st = ST_NOT_ALLOC;
                else                         w_ok = 1'b1;
            end
            K_RESIZE: begin
                if (!w_inrange || !r_valid)        w_st = ST_NOT_ALLOC;
                else if (32'(r_pad) == 32'(r_old)) w_ok = 1'b0;
                else if (w_grow_big)               w_st = ST_NO_SPACE;
                else                               w_ok = 1'b1;
            end
            default: w_st = ST_OK;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (req.valid) n_state = S_LOOKUP;
            S_LOOKUP: n_state = S_APPLY;
            S_APPLY:  n_state = S_OUT;
            S_OUT:    if (rsp.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign req.ready  = (r_state == S_IDLE);
    assign rsp.valid  = (r_state == S_OUT);
    assign rsp.status = r_st;
    assign rsp.block_offset = r_boff;
    assign rsp.free_after   = FIELD_W'(r_free);
    assign rsp.move_src = r_src;
    assign rsp.move_dst = r_dst;
    assign rsp.move_len = r_len;

    // broadcast to the cells during the apply cycle
    assign o_sel_hit  = (r_state == S_APPLY) && w_ok;
    assign o_wr_new   = (r_kind == K_ALLOC);
    assign o_wr_free  = (r_kind == K_FREE);
    assign o_wr_size  = (r_kind == K_RESIZE);
    assign o_shift    = o_sel_hit && (r_kind != K_ALLOC);
    assign o_shift_up = r_up;
    assign o_dec_rank = (r_kind == K_FREE);
    assign o_delta    = r_delta;
    assign o_ref_rank = r_rank;
    assign o_new_off  = OFF_W'(w_top);
    assign o_new_size = OFF_W'(r_pad);
    assign o_new_rank = RANK_W'(r_live);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= OFF_W'(HEAP_BYTES);
            r_live  <= '0;
        end else begin
            r_state <= n_state;
            if (o_sel_hit) begin
                case (r_kind)
                    K_ALLOC: begin
                        r_free <= r_free - OFF_W'(r_pad);
                        r_live <= r_live + CW'(1);
                    end
                    K_FREE: begin
                        r_free <= r_free + r_old;
                        r_live <= r_live - CW'(1);
                    end
                    default: r_free <= r_up ? r_free - r_delta : r_free + r_delta;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req.valid && req.ready) begin
            r_kind   <= t_kind'(req.kind);
            r_handle <= req.handle;
            r_pad    <= w_pad;
        end
        if (r_state == S_LOOKUP) begin
            r_valid <= i_hit && i_pvalid;
            r_off   <= i_poff;
            r_old   <= i_psize;
            r_rank  <= i_prank;
            if (r_kind == K_FREE) begin
                r_delta <= i_psize;
                r_up    <= 1'b0;
            end else if (32'(r_pad) > 32'(i_psize)) begin
                r_delta <= OFF_W'(32'(r_pad) - 32'(i_psize));
                r_up    <= 1'b1;
            end else begin
                r_delta <= OFF_W'(32'(i_psize) - 32'(r_pad));
                r_up    <= 1'b0;
            end
        end
        if (r_state == S_APPLY) begin
            r_st   <= w_st;
            r_boff <= '0;
            r_src  <= '0;
            r_dst  <= '0;
            r_len  <= '0;
            if (w_st == ST_OK && r_kind != K_NONE) begin
                if (r_kind == K_ALLOC) r_boff <= FIELD_W'(w_top);
                else                   r_boff <= FIELD_W'(r_off);
                if (w_ok && r_kind != K_ALLOC && w_lenx != '0) begin
                    r_len <= FIELD_W'(w_lenx);
                    r_src <= FIELD_W'(w_srcx);
                    r_dst <= (r_kind == K_FREE) ? FIELD_W'(r_off)
                                                : FIELD_W'(32'(r_off) + 32'(r_pad));
                end
            end
        end
    end
endmodule

// ===== sv/compacting_block_allocator_unit.sv =====
// Compacting block allocator.
// Request channel i_req carries kind (allocate, free, resize), handle and
// size_bytes; result channel o_rsp carries status, block offset, free bytes
// after the request and a move descriptor (src, dst, len) for an external
// data mover. Blocks are kept packed from offset zero; free and resize
// shift every later block at once through a row of per-handle cells.
// One request at a time: accept, read the handle's entry out of the cell
// chain in the lookup state, apply the update to all cells in the apply
// state, then hold the result in the output register with o_rsp.valid high.
// A new request is accepted only after the result has been taken.
// Reset (synchronous, active low) clears every handle and restores the
// full heap. While the receiver stalls the result holds and no new
// request is accepted.
module compacting_block_allocator_unit
    import cba_pkg::*;
#(
    parameter int unsigned HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int unsigned ALIGN_BYTES = ALIGN_BYTES_DEF,
    parameter int unsigned NUM_HANDLES = NUM_HANDLES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cba_req_if.sink   i_req,
    cba_rsp_if.source o_rsp
);
    localparam int unsigned OFF_W  = $clog2(HEAP_BYTES + 1);
    localparam int unsigned RANK_W = $clog2(NUM_HANDLES);
    localparam int unsigned IDX_W  = $clog2(NUM_HANDLES);

    logic [IDX_W-1:0]  w_sel;
    logic              w_sel_hit, w_wr_new, w_wr_free, w_wr_size;
    logic              w_shift, w_up, w_dec;
    logic [OFF_W-1:0]  w_delta, w_noff, w_nsize;
    logic [RANK_W-1:0] w_rrank, w_nrank;

    logic              c_hit   [NUM_HANDLES+1];
    logic              c_valid [NUM_HANDLES+1];
    logic [OFF_W-1:0]  c_off   [NUM_HANDLES+1];
    logic [OFF_W-1:0]  c_size  [NUM_HANDLES+1];
    logic [RANK_W-1:0] c_rank  [NUM_HANDLES+1];

    assign c_hit[0]   = 1'b0;
    assign c_valid[0] = 1'b0;
    assign c_off[0]   = '0;
    assign c_size[0]  = '0;
    assign c_rank[0]  = '0;

    cba_ctrl #(
        .HEAP_BYTES(HEAP_BYTES), .ALIGN_BYTES(ALIGN_BYTES),
        .NUM_HANDLES(NUM_HANDLES), .OFF_W(OFF_W), .RANK_W(RANK_W), .IDX_W(IDX_W)
    ) u_ctrl (
        .i_clk, .i_rst_n, .req(i_req), .rsp(o_rsp),
        .o_sel(w_sel), .o_sel_hit(w_sel_hit), .o_wr_new(w_wr_new),
        .o_wr_free(w_wr_free), .o_wr_size(w_wr_size), .o_shift(w_shift),
        .o_shift_up(w_up), .o_dec_rank(w_dec), .o_delta(w_delta),
        .o_ref_rank(w_rrank), .o_new_off(w_noff), .o_new_size(w_nsize),
        .o_new_rank(w_nrank),
        .i_hit(c_hit[NUM_HANDLES]), .i_pvalid(c_valid[NUM_HANDLES]),
        .i_poff(c_off[NUM_HANDLES]), .i_psize(c_size[NUM_HANDLES]),
        .i_prank(c_rank[NUM_HANDLES])
    );

    // row of handle cells
    for (genvar g = 0; g < NUM_HANDLES; g++) begin : g_cell
        cba_cell #(
            .OFF_W(OFF_W), .RANK_W(RANK_W), .IDX_W(IDX_W), .MY_IDX(g)
        ) u_cell (
            .i_clk, .i_rst_n,
            .i_sel_hit(w_sel_hit), .i_sel(w_sel), .i_wr_new(w_wr_new),
            .i_wr_free(w_wr_free), .i_wr_size(w_wr_size), .i_shift(w_shift),
            .i_shift_up(w_up), .i_dec_rank(w_dec), .i_delta(w_delta),
            .i_ref_rank(w_rrank), .i_new_off(w_noff), .i_new_size(w_nsize),
            .i_new_rank(w_nrank),
            .i_hit(c_hit[g]), .i_pvalid(c_valid[g]), .i_poff(c_off[g]),
            .i_psize(c_size[g]), .i_prank(c_rank[g]),
            .o_hit(c_hit[g+1]), .o_pvalid(c_valid[g+1]), .o_poff(c_off[g+1]),
            .o_psize(c_size[g+1]), .o_prank(c_rank[g+1])
        );
    end
endmodule

// ===== sv/cba_checker.sv =====
module cba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [15:0] block_offset,
    input logic [15:0] move_len,
    input logic [15:0] move_src
);
    // a result held while stalled stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
        else $error("result dropped under stall");
    // no new request while a result is pending
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while result pending");
    // a failed request reports no offset and no move
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && status != 2'd0 |->
            move_len == 16'd0 && move_src == 16'd0 && block_offset == 16'd0)
        else $error("failure with move");
    // an accepted request gives a result once the lookup and apply states have passed
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |-> ##3 rsp_valid)
        else $error("result latency");
endmodule

bind compacting_block_allocator_unit cba_checker u_cba_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready),
    .status(o_rsp.status), .block_offset(o_rsp.block_offset),
    .move_len(o_rsp.move_len), .move_src(o_rsp.move_src)
);
